[design/bdch_pkg.sv]
`default_nettype none

package bdch_pkg;

  localparam int TimeWidth    = 16;
  localparam int CountWidth   = 4;
  localparam int CountMax     = 15;
  localparam int AddrWidth    = 5;
  localparam int DataWidth    = 32;
  localparam int RegIdxWidth  = 3;

  localparam int DefMaxClicks = 15;
  localparam int DefLevel1Ms  = 1000;
  localparam int DefLevel2Ms  = 2000;
  localparam int DefLevel3Ms  = 4000;

  typedef logic [TimeWidth-1:0] time_ms_t;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_DEBOUNCE        = 3'd0,
    REG_RELEASE_TIMEOUT = 3'd1,
    REG_HOLD_THRESHOLD  = 3'd2,
    REG_REPEAT_RATE1    = 3'd3,
    REG_REPEAT_RATE2    = 3'd4,
    REG_REPEAT_RATE3    = 3'd5,
    REG_REPEAT_RATE4    = 3'd6
  } reg_idx_t;

  localparam time_ms_t RstDebounce       = 16'd20;
  localparam time_ms_t RstReleaseTimeout = 16'd400;
  localparam time_ms_t RstHoldThreshold  = 16'd500;
  localparam time_ms_t RstRepeatRate1    = 16'd300;
  localparam time_ms_t RstRepeatRate2    = 16'd200;
  localparam time_ms_t RstRepeatRate3    = 16'd100;
  localparam time_ms_t RstRepeatRate4    = 16'd50;

  typedef struct packed {
    time_ms_t debounce_ms;
    time_ms_t release_timeout_ms;
    time_ms_t hold_threshold_ms;
    time_ms_t repeat_rate1_ms;
    time_ms_t repeat_rate2_ms;
    time_ms_t repeat_rate3_ms;
    time_ms_t repeat_rate4_ms;
  } cfg_t;

endpackage

`default_nettype wire

[design/bdch_if.sv]
`default_nettype none

interface bdch_poll_if;
  logic                     valid;
  logic                     ready;
  logic [bdch_pkg::TimeWidth-1:0] now_ms;
  logic                     pin_low;

  modport source (output valid, output now_ms, output pin_low, input ready);
  modport sink (input valid, input now_ms, input pin_low, output ready);
endinterface

interface bdch_report_if;
  logic                            valid;
  logic                            ready;
  logic [bdch_pkg::CountWidth-1:0] click_count;
  logic                            pressed;
  logic                            held;
  logic                            timed_out;
  logic                            any_event;

  modport source (output valid, output click_count, output pressed, output held,
                  output timed_out, output any_event, input ready);
  modport sink (input valid, input click_count, input pressed, input held,
                input timed_out, input any_event, output ready);
endinterface

`default_nettype wire

[design/bdch_cfg.sv]
`default_nettype none

module bdch_cfg (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [bdch_pkg::AddrWidth-1:0]      paddr,
  input  wire  [bdch_pkg::DataWidth-1:0]      pwdata,
  output logic [bdch_pkg::DataWidth-1:0]      prdata,
  output logic                                pready,
  output bdch_pkg::cfg_t                      cfg
);

  logic                 wr_en;
  bdch_pkg::reg_idx_t   idx;
  bdch_pkg::time_ms_t   wdata;
  bdch_pkg::time_ms_t   rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = bdch_pkg::reg_idx_t'(paddr[bdch_pkg::AddrWidth-1:2]);
  assign wdata  = pwdata[bdch_pkg::TimeWidth-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms        <= bdch_pkg::RstDebounce;
      cfg.release_timeout_ms <= bdch_pkg::RstReleaseTimeout;
      cfg.hold_threshold_ms  <= bdch_pkg::RstHoldThreshold;
      cfg.repeat_rate1_ms    <= bdch_pkg::RstRepeatRate1;
      cfg.repeat_rate2_ms    <= bdch_pkg::RstRepeatRate2;
      cfg.repeat_rate3_ms    <= bdch_pkg::RstRepeatRate3;
      cfg.repeat_rate4_ms    <= bdch_pkg::RstRepeatRate4;
    end else if (wr_en) begin
      case (idx)
        bdch_pkg::REG_DEBOUNCE:        cfg.debounce_ms        <= wdata;
        bdch_pkg::REG_RELEASE_TIMEOUT: cfg.release_timeout_ms <= wdata;
        bdch_pkg::REG_HOLD_THRESHOLD:  cfg.hold_threshold_ms  <= wdata;
        bdch_pkg::REG_REPEAT_RATE1:    cfg.repeat_rate1_ms    <= wdata;
        bdch_pkg::REG_REPEAT_RATE2:    cfg.repeat_rate2_ms    <= wdata;
        bdch_pkg::REG_REPEAT_RATE3:    cfg.repeat_rate3_ms    <= wdata;
        bdch_pkg::REG_REPEAT_RATE4:    cfg.repeat_rate4_ms    <= wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      bdch_pkg::REG_DEBOUNCE:        rd_val = cfg.debounce_ms;
      bdch_pkg::REG_RELEASE_TIMEOUT: rd_val = cfg.release_timeout_ms;
      bdch_pkg::REG_HOLD_THRESHOLD:  rd_val = cfg.hold_threshold_ms;
      bdch_pkg::REG_REPEAT_RATE1:    rd_val = cfg.repeat_rate1_ms;
      bdch_pkg::REG_REPEAT_RATE2:    rd_val = cfg.repeat_rate2_ms;
      bdch_pkg::REG_REPEAT_RATE3:    rd_val = cfg.repeat_rate3_ms;
      bdch_pkg::REG_REPEAT_RATE4:    rd_val = cfg.repeat_rate4_ms;
      default:                       rd_val = '0;
    endcase
  end

  assign prdata = {{(bdch_pkg::DataWidth-bdch_pkg::TimeWidth){1'b0}}, rd_val};

endmodule

`default_nettype wire

[design/bdch_core.sv]
`default_nettype none

module bdch_core #(
  parameter int MAX_CLICKS = bdch_pkg::DefMaxClicks,
  parameter int LEVEL1_MS  = bdch_pkg::DefLevel1Ms,
  parameter int LEVEL2_MS  = bdch_pkg::DefLevel2Ms,
  parameter int LEVEL3_MS  = bdch_pkg::DefLevel3Ms
) (
  input  wire                  clk,
  input  wire                  rst,
  input  bdch_pkg::cfg_t       cfg,
  bdch_poll_if.sink            poll,
  bdch_report_if.source        report
);

  localparam logic [bdch_pkg::CountWidth-1:0] ClickLimit =
    (MAX_CLICKS > bdch_pkg::CountMax) ? bdch_pkg::CountWidth'(bdch_pkg::CountMax)
                                      : bdch_pkg::CountWidth'(MAX_CLICKS);
  localparam bdch_pkg::time_ms_t Level1 = bdch_pkg::TimeWidth'(LEVEL1_MS);
  localparam bdch_pkg::time_ms_t Level2 = bdch_pkg::TimeWidth'(LEVEL2_MS);
  localparam bdch_pkg::time_ms_t Level3 = bdch_pkg::TimeWidth'(LEVEL3_MS);

  // Input register.
  logic                in_valid;
  bdch_pkg::time_ms_t  in_now;
  logic                in_pin;

  // Button state.
  logic                               debounced_level;
  bdch_pkg::time_ms_t                 transition_time;
  bdch_pkg::time_ms_t                 repeat_time;
  logic [bdch_pkg::CountWidth-1:0]    count_store;
  logic                               press_flag;
  logic                               hold_flag;
  logic                               timeout_flag;

  logic                               debounced_level_next;
  bdch_pkg::time_ms_t                 transition_time_next;
  bdch_pkg::time_ms_t                 repeat_time_next;
  logic [bdch_pkg::CountWidth-1:0]    count_store_next;
  logic                               press_flag_next;
  logic                               hold_flag_next;
  logic                               timeout_flag_next;

  logic                               out_load;
  logic                               advance;
  logic [bdch_pkg::CountWidth-1:0]    cnt0;
  logic                               prs0;
  logic                               hld0;
  bdch_pkg::time_ms_t                 elapsed;
  bdch_pkg::time_ms_t                 rep_elapsed;
  bdch_pkg::time_ms_t                 interval;
  logic                               report_now;
  logic                               any_next;

  assign out_load   = !report.valid || report.ready;
  assign advance    = in_valid && out_load;
  assign poll.ready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
    if (poll.valid && poll.ready) begin
      in_now <= poll.now_ms;
      in_pin <= poll.pin_low;
    end
  end

  assign elapsed     = in_now - transition_time;
  assign rep_elapsed = in_now - repeat_time;

  always_comb begin
    if (elapsed >= Level3) begin
      interval = cfg.repeat_rate4_ms;
    end else if (elapsed >= Level2) begin
      interval = cfg.repeat_rate3_ms;
    end else if (elapsed >= Level1) begin
      interval = cfg.repeat_rate2_ms;
    end else if (elapsed >= cfg.hold_threshold_ms) begin
      interval = cfg.repeat_rate1_ms;
    end else begin
      interval = cfg.hold_threshold_ms;
    end
  end

  always_comb begin
    // A timeout reported on the previous poll clears the sequence first.
    cnt0 = timeout_flag ? '0 : count_store;
    prs0 = timeout_flag ? 1'b0 : press_flag;
    hld0 = timeout_flag ? 1'b0 : hold_flag;

    debounced_level_next = debounced_level;
    transition_time_next = transition_time;
    repeat_time_next     = repeat_time;
    count_store_next     = cnt0;
    press_flag_next      = prs0;
    hold_flag_next       = hld0;
    timeout_flag_next    = 1'b0;
    report_now           = 1'b0;

    if (elapsed > cfg.debounce_ms) begin
      if (in_pin != debounced_level) begin
        debounced_level_next = in_pin;
        transition_time_next = in_now;
        repeat_time_next     = in_now;
        report_now           = 1'b1;
        if (in_pin) begin
          press_flag_next  = 1'b1;
          count_store_next = (cnt0 < ClickLimit) ? cnt0 + 1'b1 : cnt0;
        end else begin
          press_flag_next   = 1'b0;
          timeout_flag_next = hld0;
        end
      end else if (!in_pin && (cnt0 != '0 || prs0 || hld0) &&
                   elapsed > cfg.release_timeout_ms) begin
        timeout_flag_next = 1'b1;
        report_now        = 1'b1;
      end else if (in_pin && rep_elapsed > interval) begin
        hold_flag_next   = 1'b1;
        repeat_time_next = in_now;
        report_now       = 1'b1;
      end
    end

    any_next = report_now && (count_store_next != '0 || press_flag_next ||
                              hold_flag_next || timeout_flag_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_level <= 1'b0;
      transition_time <= '0;
      repeat_time     <= '0;
      count_store     <= '0;
      press_flag      <= 1'b0;
      hold_flag       <= 1'b0;
      timeout_flag    <= 1'b0;
    end else if (advance) begin
      debounced_level <= debounced_level_next;
      transition_time <= transition_time_next;
      repeat_time     <= repeat_time_next;
      count_store     <= count_store_next;
      press_flag      <= press_flag_next;
      hold_flag       <= hold_flag_next;
      timeout_flag    <= timeout_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (out_load) begin
      report.valid <= in_valid;
    end
    if (advance) begin
      report.click_count <= any_next ? count_store_next : '0;
      report.pressed     <= any_next && press_flag_next;
      report.held        <= any_next && hold_flag_next;
      report.timed_out   <= any_next && timeout_flag_next;
      report.any_event   <= any_next;
    end
  end

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count_store <= ClickLimit)
    else $error("click count above its limit");

  a_press_level: assert property (@(posedge clk) disable iff (rst)
    press_flag |-> debounced_level)
    else $error("press flag set while debounced level is released");

  a_timeout_released: assert property (@(posedge clk) disable iff (rst)
    timeout_flag |-> !press_flag && !debounced_level)
    else $error("timeout flag set while button is down");

  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    report.valid && !report.any_event |->
      report.click_count == '0 && !report.pressed && !report.held && !report.timed_out)
    else $error("word without event carries nonzero fields");

  a_clear_after_timeout: assert property (@(posedge clk) disable iff (rst)
    advance && timeout_flag |=> !hold_flag || $past(report_now))
    else $error("hold flag survived a reported timeout");
`endif

endmodule

`default_nettype wire

[design/button_debounce_click_hold.sv]
// Button debouncer with click counting, hold repeat and sequence timeout.
// The poll channel carries one word per poll: a 16-bit millisecond time
// that wraps at 2^16 and the raw pin level, where one means pressed.
// The report channel returns exactly one word per poll, in order, with
// the click count and the pressed, held and timed_out flags; any_event
// is zero and all other fields are zero when the poll reports nothing.
// A poll is taken into an input register and its report is written to
// the output register when that register is free or being read, and one
// poll can be accepted every cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its word and the
// input register can still take one more poll before ready drops.
// The timing registers sit behind an APB port and should only be written
// while no poll is in flight. Reset clears all button state and the two
// pipeline valids and loads the default timing values.
`default_nettype none

module button_debounce_click_hold #(
  parameter int MAX_CLICKS = bdch_pkg::DefMaxClicks,
  parameter int LEVEL1_MS  = bdch_pkg::DefLevel1Ms,
  parameter int LEVEL2_MS  = bdch_pkg::DefLevel2Ms,
  parameter int LEVEL3_MS  = bdch_pkg::DefLevel3Ms
) (
  input  wire                              clk,
  input  wire                              rst,
  bdch_poll_if.sink                        poll,
  bdch_report_if.source                    report,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [bdch_pkg::AddrWidth-1:0]   paddr,
  input  wire  [bdch_pkg::DataWidth-1:0]   pwdata,
  output logic [bdch_pkg::DataWidth-1:0]   prdata,
  output logic                             pready
);

  bdch_pkg::cfg_t cfg;

  bdch_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdch_core #(
    .MAX_CLICKS (MAX_CLICKS),
    .LEVEL1_MS  (LEVEL1_MS),
    .LEVEL2_MS  (LEVEL2_MS),
    .LEVEL3_MS  (LEVEL3_MS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .poll   (poll),
    .report (report)
  );

endmodule

`default_nettype wire
